// ----- hw/rtl/lir_pkg.sv -----
// Shared types and constants for the linear interpolation resampler.
// No dependencies; every other file of the block refers to this package.

package lir_pkg;

    // Default sizing of the datapath.
    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int FRAC_WIDTH_DEF   = 16;
    localparam int MAX_RATIO_DEF    = 64;

    // Fixed widths of the step register and of the sample fields on the ports.
    localparam int STEP_W = 32;
    localparam int PORT_W = 32;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_START,
        ST_WAIT,
        ST_EMIT
    } ctrl_state_t;

    // Sequencer to serial interpolator.
    typedef struct packed {
        logic start;
    } mac_ctl_t;

    // Serial interpolator back to the sequencer.
    typedef struct packed {
        logic done;
    } mac_sts_t;

    // Sequencer to the output register.
    typedef struct packed {
        logic load;
        logic last;
    } emit_t;

endpackage

// ----- hw/rtl/lir_if.sv -----
// Valid/ready stream interfaces for the resampler's input and output beats.
// Depends on lir_pkg for the port field widths.

interface lir_in_if;
    logic                        valid;
    logic                        ready;
    logic [lir_pkg::PORT_W-1:0]  sample_in;

    modport source  (output valid, output sample_in, input ready);
    modport sink    (input valid, input sample_in, output ready);
    modport monitor (input valid, input ready, input sample_in);
endinterface

interface lir_out_if;
    logic                        valid;
    logic                        ready;
    logic [lir_pkg::PORT_W-1:0]  sample_out;
    logic                        last_of_run;

    modport source  (output valid, output sample_out, output last_of_run, input ready);
    modport sink    (input valid, input sample_out, input last_of_run, output ready);
    modport monitor (input valid, input ready, input sample_out, input last_of_run);
endinterface

// ----- hw/rtl/lir_mac.sv -----
// Serial interpolator: base + diff * frac / 2^FRAC_WIDTH, truncated toward zero.
// One fraction bit is consumed per cycle by a shift-and-add multiplier.
// Depends on lir_pkg for the control and status structs.

module lir_mac #(
    parameter int SAMPLE_WIDTH = lir_pkg::SAMPLE_WIDTH_DEF,
    parameter int FRAC_WIDTH   = lir_pkg::FRAC_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lir_pkg::mac_ctl_t            ctl,
    input  logic signed [SAMPLE_WIDTH-1:0] base,
    input  logic signed [SAMPLE_WIDTH:0]   diff,
    input  logic [FRAC_WIDTH-1:0]        frac,
    output lir_pkg::mac_sts_t            sts,
    output logic signed [SAMPLE_WIDTH-1:0] result
);

    localparam int HW = SAMPLE_WIDTH + 2;
    localparam int CW = $clog2(FRAC_WIDTH + 1);

    logic                  busy_reg, busy_next;
    logic                  fin_reg, fin_next;
    logic                  done_reg, done_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic signed [HW-1:0]  hi_reg, hi_next;
    logic [FRAC_WIDTH-1:0] lo_reg, lo_next;
    logic signed [HW-1:0]  q_reg, q_next;
    logic                  nz_reg, nz_next;

    logic signed [HW-1:0]  addend;
    logic signed [HW-1:0]  sum;
    logic signed [HW-1:0]  q_adj;
    logic                  last_bit;

    // Partial product step: add diff when the current fraction bit is set.
    assign addend   = lo_reg[0] ? HW'(diff) : '0;
    assign sum      = hi_reg + addend;
    assign last_bit = (cnt_reg == CW'(1));

    // Control flags of the multiplier.
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(FRAC_WIDTH);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - CW'(1);
            if (last_bit)
            begin
                busy_next = 1'b0;
            end
        end
        fin_next  = busy_reg && last_bit;
        done_next = fin_reg;
    end

    // Product shift register and the final add of the base sample.
    always_comb
    begin
        hi_next = hi_reg;
        lo_next = lo_reg;
        q_next  = q_reg;
        nz_next = nz_reg;
        if (ctl.start)
        begin
            hi_next = '0;
            lo_next = frac;
        end
        else if (busy_reg)
        begin
            hi_next = sum >>> 1;
            lo_next = {sum[0], lo_reg[FRAC_WIDTH-1:1]};
        end
        if (fin_reg)
        begin
            q_next  = hi_reg + HW'(base);
            nz_next = |lo_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg <= hi_next;
        lo_reg <= lo_next;
        q_reg  <= q_next;
        nz_reg <= nz_next;
    end

    // The floor quotient moves up by one when it is negative and inexact.
    assign q_adj    = q_reg + HW'({1'b0, q_reg[HW-1] && nz_reg});
    assign result   = q_adj[SAMPLE_WIDTH-1:0];
    assign sts.done = done_reg;

endmodule

// ----- hw/rtl/lir_ctrl.sv -----
// Resampler sequencer: input beats, position tracking and the run of outputs.
// Depends on lir_pkg for the state type and the inter-module structs.

module lir_ctrl #(
    parameter int SAMPLE_WIDTH = lir_pkg::SAMPLE_WIDTH_DEF,
    parameter int FRAC_WIDTH   = lir_pkg::FRAC_WIDTH_DEF,
    parameter int MAX_RATIO    = lir_pkg::MAX_RATIO_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic [SAMPLE_WIDTH-1:0]        in_sample,
    output logic                           in_ready,
    input  logic [lir_pkg::STEP_W-1:0]     step,
    output lir_pkg::mac_ctl_t              mac_ctl,
    input  lir_pkg::mac_sts_t              mac_sts,
    output logic signed [SAMPLE_WIDTH-1:0] base,
    output logic signed [SAMPLE_WIDTH:0]   diff,
    output logic [FRAC_WIDTH-1:0]          frac,
    input  logic                           out_free,
    output lir_pkg::emit_t                 emit
);

    localparam int STEP_W = lir_pkg::STEP_W;
    localparam int AW     = STEP_W + 1 - FRAC_WIDTH;
    localparam int NW     = (MAX_RATIO > 1) ? $clog2(MAX_RATIO) : 1;
    localparam logic [STEP_W-1:0] MIN_STEP = STEP_W'((1 << FRAC_WIDTH) / MAX_RATIO);

    lir_pkg::ctrl_state_t state_reg, state_next;

    logic                           primed_reg, primed_next;
    logic [AW-1:0]                  ahead_reg, ahead_next;
    logic [NW-1:0]                  n_reg, n_next;
    logic [FRAC_WIDTH-1:0]          frac_reg, frac_next;
    logic signed [SAMPLE_WIDTH-1:0] prev_reg, prev_next;
    logic signed [SAMPLE_WIDTH-1:0] cur_reg, cur_next;
    logic signed [SAMPLE_WIDTH:0]   diff_reg, diff_next;

    logic [STEP_W-1:0]              inc;
    logic [STEP_W:0]                pos_sum;
    logic [AW-1:0]                  jump;
    logic                           run_end;
    logic                           skip;

    // Position advance; small steps are raised to the minimum.
    assign inc     = (step < MIN_STEP) ? MIN_STEP : step;
    assign pos_sum = (STEP_W + 1)'(frac_reg) + (STEP_W + 1)'(inc);
    assign jump    = pos_sum[STEP_W:FRAC_WIDTH];
    assign run_end = (jump != '0) || (n_reg == NW'(MAX_RATIO - 1));

    // An input that only primes or falls inside a jump produces nothing.
    assign skip = !primed_reg || (ahead_reg != '0);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lir_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = lir_pkg::ST_DECIDE;
                end
            end
            lir_pkg::ST_DECIDE:
            begin
                state_next = skip ? lir_pkg::ST_IDLE : lir_pkg::ST_START;
            end
            lir_pkg::ST_START:
            begin
                state_next = lir_pkg::ST_WAIT;
            end
            lir_pkg::ST_WAIT:
            begin
                if (mac_sts.done)
                begin
                    state_next = lir_pkg::ST_EMIT;
                end
            end
            lir_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = run_end ? lir_pkg::ST_IDLE : lir_pkg::ST_START;
                end
            end
            default:
            begin
                state_next = lir_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        in_ready      = 1'b0;
        mac_ctl.start = 1'b0;
        emit.load     = 1'b0;
        emit.last     = run_end;
        unique case (state_reg)
            lir_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            lir_pkg::ST_START:
            begin
                mac_ctl.start = 1'b1;
            end
            lir_pkg::ST_EMIT:
            begin
                emit.load = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Sample and position registers.
    always_comb
    begin
        primed_next = primed_reg;
        ahead_next  = ahead_reg;
        n_next      = n_reg;
        frac_next   = frac_reg;
        prev_next   = prev_reg;
        cur_next    = cur_reg;
        diff_next   = diff_reg;
        unique case (state_reg)
            lir_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cur_next = in_sample;
                end
            end
            lir_pkg::ST_DECIDE:
            begin
                if (!primed_reg)
                begin
                    primed_next = 1'b1;
                    prev_next   = cur_reg;
                end
                else if (ahead_reg != '0)
                begin
                    ahead_next = ahead_reg - AW'(1);
                    prev_next  = cur_reg;
                end
                else
                begin
                    diff_next = (SAMPLE_WIDTH + 1)'(cur_reg) - (SAMPLE_WIDTH + 1)'(prev_reg);
                    n_next    = '0;
                end
            end
            lir_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    frac_next = pos_sum[FRAC_WIDTH-1:0];
                    if (run_end)
                    begin
                        ahead_next = (jump != '0) ? (jump - AW'(1)) : '0;
                        prev_next  = cur_reg;
                    end
                    else
                    begin
                        n_next = n_reg + NW'(1);
                    end
                end
            end
            default:
            begin
                n_next = n_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= lir_pkg::ST_IDLE;
            primed_reg <= 1'b0;
            ahead_reg  <= '0;
            n_reg      <= '0;
            frac_reg   <= '0;
            prev_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            primed_reg <= primed_next;
            ahead_reg  <= ahead_next;
            n_reg      <= n_next;
            frac_reg   <= frac_next;
            prev_reg   <= prev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        diff_reg <= diff_next;
    end

    assign base = prev_reg;
    assign diff = diff_reg;
    assign frac = frac_reg;

endmodule

// ----- hw/rtl/linear_interp_resampler_top.sv -----
// Linear interpolation sample rate converter: top level with the step register
// and the output register. Depends on lir_pkg, lir_if, lir_ctrl and lir_mac.
//
// Each output sample is computed by the shift-and-add interpolator, which
// takes one fraction bit per cycle. An input beat keeps the block busy until
// its k outputs are issued, with k at most MAX_RATIO; an input that only primes
// the previous sample or falls inside a whole-sample jump causes no output. The
// output register lets the next output be computed while the current one waits,
// and an output backpressure stall holds the sequencer until that register is
// free. Write the step register only while the block is idle; it resets to 1.0.

module linear_interp_resampler_top #(
    parameter int SAMPLE_WIDTH = lir_pkg::SAMPLE_WIDTH_DEF,
    parameter int FRAC_WIDTH   = lir_pkg::FRAC_WIDTH_DEF,
    parameter int MAX_RATIO    = lir_pkg::MAX_RATIO_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [lir_pkg::STEP_W-1:0] cfg_wdata,
    lir_in_if.sink                     in_ch,
    lir_out_if.source                  out_ch
);

    localparam int STEP_W = lir_pkg::STEP_W;
    localparam int PORT_W = lir_pkg::PORT_W;
    localparam logic [STEP_W-1:0] STEP_ONE = STEP_W'(1) << FRAC_WIDTH;

    logic [STEP_W-1:0]              step_reg, step_next;
    logic                           out_valid_reg, out_valid_next;
    logic signed [PORT_W-1:0]       out_sample_reg, out_sample_next;
    logic                           out_last_reg, out_last_next;

    lir_pkg::mac_ctl_t              mac_ctl;
    lir_pkg::mac_sts_t              mac_sts;
    lir_pkg::emit_t                 emit;
    logic signed [SAMPLE_WIDTH-1:0] base;
    logic signed [SAMPLE_WIDTH:0]   diff;
    logic [FRAC_WIDTH-1:0]          frac;
    logic signed [SAMPLE_WIDTH-1:0] mac_result;
    logic                           out_free;
    logic                           in_ready;

    // Step register.
    assign step_next = cfg_we ? cfg_wdata : step_reg;

    // Output register: loads a result beat, clears when the beat is taken.
    assign out_free = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_sample_next = out_sample_reg;
        out_last_next   = out_last_reg;
        if (emit.load)
        begin
            out_valid_next  = 1'b1;
            out_sample_next = PORT_W'(mac_result);
            out_last_next   = emit.last;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_ONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_sample_reg <= out_sample_next;
        out_last_reg   <= out_last_next;
    end

    lir_ctrl #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .FRAC_WIDTH   (FRAC_WIDTH),
        .MAX_RATIO    (MAX_RATIO)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_sample (in_ch.sample_in[SAMPLE_WIDTH-1:0]),
        .in_ready  (in_ready),
        .step      (step_reg),
        .mac_ctl   (mac_ctl),
        .mac_sts   (mac_sts),
        .base      (base),
        .diff      (diff),
        .frac      (frac),
        .out_free  (out_free),
        .emit      (emit)
    );

    lir_mac #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .FRAC_WIDTH   (FRAC_WIDTH)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mac_ctl),
        .base   (base),
        .diff   (diff),
        .frac   (frac),
        .sts    (mac_sts),
        .result (mac_result)
    );

    assign in_ch.ready        = in_ready;
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.sample_out  = out_sample_reg;
    assign out_ch.last_of_run = out_last_reg;

endmodule

// ----- hw/rtl/lir_checker.sv -----
// Port-level checks for the resampler, bound to the top level.
// Depends on lir_pkg for the port field widths and on the top level's ports.

module lir_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [lir_pkg::PORT_W-1:0] out_sample,
    input logic                       out_last
);

    // A stalled output beat stays offered.
    a_out_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output beat withdrawn while stalled");

    // A stalled output beat keeps its payload.
    a_out_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_sample) && $stable(out_last))
        else $error("output payload changed while stalled");

    // One input beat at a time: the block is busy right after taking one.
    a_in_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted on consecutive cycles");

    // Results only appear while an input beat is being worked on.
    a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("output appeared while the block was idle");

    // A run is not finished while one of its inner outputs is pending.
    a_run_open: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_last |-> !in_ready)
        else $error("input taken before the current run ended");

endmodule

bind linear_interp_resampler_top lir_checker u_lir_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_sample (out_ch.sample_out),
    .out_last   (out_ch.last_of_run)
);

// ----- tb/sv/linear_interp_resampler_top_tb.sv -----
// Self-checking testbench for the linear interpolation resampler top level.
// Depends on lir_pkg, lir_if and the RTL of linear_interp_resampler_top.
// A scoreboard class predicts every output beat; plain tasks drive the block.

`timescale 1ns / 1ps

module linear_interp_resampler_top_tb;

    localparam int     PORT_W        = lir_pkg::PORT_W;
    localparam int     STEP_W        = lir_pkg::STEP_W;
    localparam int     FRAC_W        = lir_pkg::FRAC_WIDTH_DEF;
    localparam int     RATIO_CAP     = lir_pkg::MAX_RATIO_DEF;
    localparam longint ONE_POS       = longint'(1) << FRAC_W;
    localparam longint MIN_INC       = ONE_POS / RATIO_CAP;
    localparam int     SETTLE_CYCLES = 32;
    localparam int     END_CYCLES    = 200;
    localparam int     LONG_HOLD     = 400;
    localparam int     QUIET_LIMIT   = 4000;
    localparam int     PHASE_ITEMS   = 9;

    // One expected output beat.
    typedef struct packed {
        logic [PORT_W-1:0] sample;
        logic              last;
    } run_beat_t;

    // Predicts the interpolated output run of each accepted sample and
    // checks the output beats against it in order.
    class resample_scoreboard;
        logic [STEP_W-1:0]        step_reg;
        logic signed [PORT_W-1:0] prev_sample;
        logic [16:0]              skip_left;
        logic [FRAC_W-1:0]        pos_frac;
        bit                       primed;
        run_beat_t                expected_q[$];
        int                       error_count;

        function new();
            step_reg    = STEP_W'(ONE_POS);
            prev_sample = '0;
            skip_left   = '0;
            pos_frac    = '0;
            primed      = 1'b0;
            error_count = 0;
        endfunction

        function void set_step(logic [STEP_W-1:0] value);
            step_reg = value;
        endfunction

        // Works out the outputs caused by one accepted input sample.
        function void note_input(logic [PORT_W-1:0] raw);
            longint          cur;
            longint          prv;
            longint          wa;
            longint          wb;
            longint          sum;
            longint unsigned inc;
            longint unsigned pos;
            longint unsigned jump;
            int              n;
            run_beat_t       beat;

            cur = $signed(raw);
            // The first sample after reset only primes the history.
            if (!primed)
            begin
                primed      = 1'b1;
                prev_sample = raw;
                return;
            end
            // Inputs inside a whole-sample jump only replace the history.
            if (skip_left != 0)
            begin
                skip_left   = skip_left - 1'b1;
                prev_sample = raw;
                return;
            end
            // Small steps are raised to the minimum.
            inc = step_reg;
            if (inc < MIN_INC)
                inc = MIN_INC;
            prv  = prev_sample;
            jump = 0;
            n    = 0;
            while (jump == 0 && n < RATIO_CAP)
            begin
                wb          = pos_frac;
                wa          = ONE_POS - wb;
                sum         = prv * wa + cur * wb;
                beat.sample = PORT_W'(sum / ONE_POS);
                pos         = pos_frac + inc;
                pos_frac    = pos[FRAC_W-1:0];
                jump        = pos >> FRAC_W;
                n++;
                beat.last   = (jump != 0 || n == RATIO_CAP);
                expected_q.push_back(beat);
            end
            skip_left   = (jump > 0) ? 17'(jump - 1) : 17'd0;
            prev_sample = raw;
        endfunction

        task report_mismatch(string msg);
            error_count++;
            $display("MISMATCH at %0t ns: %s", $realtime, msg);
        endtask

        // Compares one accepted output beat with the oldest expectation.
        task check_output(logic [PORT_W-1:0] got_sample, logic got_last);
            run_beat_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected output beat sample=%0d last=%0b",
                                          $signed(got_sample), got_last));
                return;
            end
            want = expected_q.pop_front();
            if (got_sample !== want.sample)
                report_mismatch($sformatf("sample_out got %0d expected %0d",
                                          $signed(got_sample), $signed(want.sample)));
            if (got_last !== want.last)
                report_mismatch($sformatf("last_of_run got %0b expected %0b",
                                          got_last, want.last));
        endtask
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [STEP_W-1:0] cfg_wdata;

    lir_in_if  in_bus ();
    lir_out_if out_bus ();

    resample_scoreboard sb;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    bit hold_go      = 1'b0;
    bit hold_done    = 1'b0;
    int hold_left    = 0;
    int quiet_cycles = 0;

    linear_interp_resampler_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_bus),
        .out_ch    (out_bus)
    );

    // Free-running clock, 4 ns period.
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Receiver: checks accepted beats and drives ready, with an optional
    // long hold-off that is counted here.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_bus.ready <= 1'b0;
        end
        else
        begin
            if (out_bus.valid && out_bus.ready)
                sb.check_output(out_bus.sample_out, out_bus.last_of_run);
            if (hold_go && !hold_done)
            begin
                hold_done     <= 1'b1;
                hold_left     <= LONG_HOLD;
                out_bus.ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left     <= hold_left - 1;
                out_bus.ready <= 1'b0;
            end
            else
            begin
                out_bus.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Watchdog: ends the run after too many cycles without any beat.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Offers one sample, with random idle cycles ahead of it, and returns
    // at the edge where the beat is taken.
    task automatic send_sample(logic [PORT_W-1:0] s);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            in_bus.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct);
        end
        in_bus.valid     <= 1'b1;
        in_bus.sample_in <= s;
        do
            @(posedge clk);
        while (in_bus.ready !== 1'b1);
        sb.note_input(s);
    endtask

    // Stops offering and waits until every predicted output has arrived.
    task automatic wait_results();
        in_bus.valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    // Writes the step register once the block has gone idle.
    task automatic write_step(logic [STEP_W-1:0] value);
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_step(value);
    endtask

    function automatic logic [PORT_W-1:0] random_sample();
        case ($urandom_range(9))
            0: return ($urandom_range(1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1: return PORT_W'($urandom_range(200)) - 32'd100;
            default: return $urandom;
        endcase
    endfunction

    // Mostly ratios near one, some below the minimum, some with jumps.
    function automatic logic [STEP_W-1:0] random_step();
        case ($urandom_range(19))
            0, 1, 2:    return $urandom_range(1023, 0);
            3, 4, 5:    return $urandom_range(32'h0006_0000, 32'h0002_0001);
            6, 7, 8, 9: return $urandom_range(32'h0002_0000, 32'h0000_4000);
            default:    return $urandom_range(32'h0002_0000, 32'd1024);
        endcase
    endfunction

    initial
    begin
        int tx_mode[4];
        int rx_mode[4];

        tx_mode = '{0, 75, 0, 12};
        rx_mode = '{0, 0, 75, 12};
        sb = new();
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        in_bus.valid     = 1'b0;
        in_bus.sample_in = '0;
        out_bus.ready    = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset step of 1.0: each output repeats the previous sample.
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        send_sample(32'h0000_0000);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h0000_0001);

        // Half step: midpoints of opposite extremes truncate toward zero.
        write_step(32'h0000_8000);
        send_sample(32'h8000_0000);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h0000_0002);

        // Step of zero is raised to the minimum: a full run of outputs.
        write_step(32'h0000_0000);
        send_sample(32'h1234_5678);
        send_sample(32'h8000_0000);

        // Just below and at the minimum step.
        write_step(32'd1023);
        send_sample(32'h7FFF_FFFF);
        write_step(32'd1024);
        send_sample(32'hEDCB_A987);

        // Step of 1.5: some inputs fall inside a jump.
        write_step(32'h0001_8000);
        repeat (5) send_sample(random_sample());

        // Random phases under each idling pattern.
        for (int m = 0; m < 4; m++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                wait_results();
                tx_idle_pct  = tx_mode[m];
                rx_stall_pct = rx_mode[m];
                if (m == 0 && k == 0)
                begin
                    // Long receiver hold-off while inputs keep coming.
                    write_step(32'h0000_4000);
                    hold_go = 1'b1;
                end
                else
                begin
                    write_step(random_step());
                end
                for (int i = 0; i < PHASE_ITEMS; i++)
                begin
                    // Sender pause until the pipeline has drained.
                    if (m == 1 && k == 1 && i == 5)
                        wait_results();
                    send_sample(random_sample());
                end
            end
        end

        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        write_step(32'h0001_FFFF);
        repeat (6) send_sample(random_sample());

        // Largest step: one output, then every later input falls inside the jump.
        write_step(32'hFFFE_0000);
        repeat (4) send_sample(random_sample());

        wait_results();
        repeat (END_CYCLES) @(posedge clk);
        if (sb.error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
